### rtl/ofsl_pkg.sv
package ofsl_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned OUT_TDATA_W = 40;

	localparam logic [WORD_W-1:0] HDR_DATA = 16'hDADA;
	localparam logic [WORD_W-1:0] HDR_CODE = 16'hCADE;
	localparam logic [WORD_W-1:0] HDR_SYM = 16'hC3B7;
	localparam logic [WORD_W-1:0] HDR_FILE = 16'hF17E;
	localparam logic [WORD_W-1:0] HDR_LINE = 16'h715E;

	// line-number record: three words skipped as bytes
	localparam logic [WORD_W-1:0] LINE_SKIP_BYTES = 16'd6;

	typedef enum logic [1:0] {
		KIND_CODE = 2'd0,
		KIND_SYM = 2'd1,
		KIND_FILE = 2'd2,
		KIND_LINE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_BUSY = 2'd0,
		STAT_OK = 2'd1,
		STAT_BAD = 2'd2,
		STAT_TRUNC = 2'd3
	} status_t;

	typedef struct packed {
		logic write_valid;
		logic [WORD_W-1:0] write_address;
		logic [WORD_W-1:0] write_data;
		status_t load_status;
	} result_t;

endpackage

### rtl/ofsl_parser.sv
module ofsl_parser (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic [ofsl_pkg::BYTE_W-1:0] data_byte,
	input logic last_byte,
	output ofsl_pkg::result_t result
);
	import ofsl_pkg::*;

	typedef enum logic [3:0] {
		PH_HDR_HI = 4'd0,
		PH_HDR_LO = 4'd1,
		PH_ADR_HI = 4'd2,
		PH_ADR_LO = 4'd3,
		PH_CNT_HI = 4'd4,
		PH_CNT_LO = 4'd5,
		PH_WRD_HI = 4'd6,
		PH_WRD_LO = 4'd7,
		PH_SKIP = 4'd8
	} phase_t;

	phase_t phase_q, phase_d;
	logic [BYTE_W-1:0] hold_q, hold_d;
	logic [WORD_W-1:0] addr_q, addr_d;
	logic [WORD_W-1:0] count_q, count_d;
	kind_t kind_q, kind_d;
	logic err_q, err_d;
	logic [WORD_W-1:0] word;
	logic [WORD_W-1:0] count_dec;

	assign word = {hold_q, data_byte};
	assign count_dec = count_q - 1'b1;

	always_comb begin
		phase_d = phase_q;
		hold_d = hold_q;
		addr_d = addr_q;
		count_d = count_q;
		kind_d = kind_q;
		err_d = err_q;
		result = '0;
		result.load_status = STAT_BUSY;
		if (!err_q) begin
			unique case (phase_q)
				PH_HDR_LO: begin
					if (word == HDR_DATA || word == HDR_CODE) begin
						kind_d = KIND_CODE;
						phase_d = PH_ADR_HI;
					end else if (word == HDR_SYM) begin
						kind_d = KIND_SYM;
						phase_d = PH_ADR_HI;
					end else if (word == HDR_FILE) begin
						kind_d = KIND_FILE;
						phase_d = PH_CNT_HI;
					end else if (word == HDR_LINE) begin
						kind_d = KIND_LINE;
						count_d = LINE_SKIP_BYTES;
						phase_d = PH_SKIP;
					end else begin
						err_d = 1'b1;
						phase_d = PH_HDR_HI;
					end
				end
				PH_ADR_LO: begin
					addr_d = word;
					phase_d = PH_CNT_HI;
				end
				PH_CNT_LO: begin
					count_d = word;
					if (word == '0)
						phase_d = PH_HDR_HI;
					else if (kind_q == KIND_CODE)
						phase_d = PH_WRD_HI;
					else
						phase_d = PH_SKIP;
				end
				PH_WRD_LO: begin
					result.write_valid = 1'b1;
					result.write_address = addr_q;
					result.write_data = word;
					addr_d = addr_q + 1'b1;
					count_d = count_dec;
					phase_d = (count_dec == '0) ? PH_HDR_HI : PH_WRD_HI;
				end
				PH_SKIP: begin
					count_d = count_dec;
					if (count_dec == '0)
						phase_d = PH_HDR_HI;
				end
				PH_ADR_HI: begin
					hold_d = data_byte;
					phase_d = PH_ADR_LO;
				end
				PH_CNT_HI: begin
					hold_d = data_byte;
					phase_d = PH_CNT_LO;
				end
				PH_WRD_HI: begin
					hold_d = data_byte;
					phase_d = PH_WRD_LO;
				end
				default: begin
					hold_d = data_byte;
					phase_d = PH_HDR_LO;
				end
			endcase
		end
		if (last_byte) begin
			if (err_d)
				result.load_status = STAT_BAD;
			else if (phase_d != PH_HDR_HI)
				result.load_status = STAT_TRUNC;
			else
				result.load_status = STAT_OK;
			// file done: next byte starts a new file
			phase_d = PH_HDR_HI;
			hold_d = '0;
			addr_d = '0;
			count_d = '0;
			kind_d = KIND_CODE;
			err_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR_HI;
			hold_q <= '0;
			addr_q <= '0;
			count_q <= '0;
			kind_q <= KIND_CODE;
			err_q <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			hold_q <= hold_d;
			addr_q <= addr_d;
			count_q <= count_d;
			kind_q <= kind_d;
			err_q <= err_d;
		end
	end

endmodule

### rtl/ofsl_out_reg.sv
module ofsl_out_reg (
	input logic clk,
	input logic arst_n,
	input logic load,
	input ofsl_pkg::result_t result,
	input logic m_tready,
	output logic m_tvalid,
	output ofsl_pkg::result_t result_s1
);
	import ofsl_pkg::*;

	logic valid_q;

	assign m_tvalid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (m_tready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			result_s1 <= result;
	end

endmodule

### rtl/object_file_section_loader.sv
// channel | dir | tdata                                   | tuser       | tlast
// s_*     | in  | [7:0] data_byte                         | -           | last_byte
// m_*     | out | [15:0] write_address, [31:16] write_data, | write_valid | -
//         |     | [33:32] load_status, [39:34] zero       |             |
// One byte per cycle unless s_tready is low; each gives one m_* item in the next cycle.
// The parse state machine advances on each accepted byte; the result sits in the
// output register until taken.
// arst_n clears the parse state and the output valid.
// s_tready drops only while the output register holds an item that m_tready refuses.
module object_file_section_loader (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // [7:0] data_byte
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	output logic [ofsl_pkg::OUT_TDATA_W-1:0] m_tdata, // write_address, write_data, load_status
	output logic m_tuser // write_valid
);
	import ofsl_pkg::*;

	logic take;
	result_t result;
	result_t result_s1;

	assign s_tready = !m_tvalid || m_tready;
	assign take = s_tvalid && s_tready;

	ofsl_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.data_byte(s_tdata),
		.last_byte(s_tlast),
		.result(result)
	);

	ofsl_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(take),
		.result(result),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.result_s1(result_s1)
	);

	assign m_tuser = result_s1.write_valid;
	assign m_tdata = {{(OUT_TDATA_W - 2 - 2*WORD_W){1'b0}}, result_s1.load_status,
		result_s1.write_data, result_s1.write_address};

endmodule

### rtl/ofsl_checker.sv
module ofsl_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [ofsl_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic m_tuser
);
	import ofsl_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:0] == '0)
		else $error("address or data set without a write");

	a_no_write_on_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[33:32] != STAT_BAD)
		else $error("write reported with invalid header status");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted byte produced no output item");

endmodule

bind object_file_section_loader ofsl_checker u_ofsl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ofsl_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	class load_scoreboard;
		typedef enum logic [3:0] {
			P_HDR_HI, P_HDR_LO, P_ADR_HI, P_ADR_LO, P_CNT_HI,
			P_CNT_LO, P_WRD_HI, P_WRD_LO, P_SKIP
		} phase_t;

		phase_t phase;
		logic [7:0] hold;
		logic [15:0] addr;
		logic [15:0] count;
		kind_t kind;
		logic err;
		result_t writes_due[$];
		int errors;

		function new();
			clear();
			errors = 0;
		endfunction

		function void clear();
			phase = P_HDR_HI;
			hold = '0;
			addr = '0;
			count = '0;
			kind = KIND_CODE;
			err = 1'b0;
		endfunction

		function int pending();
			return writes_due.size();
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			result_t r;
			logic [15:0] w;
			r = '0;
			r.load_status = STAT_BUSY;
			w = {hold, b};
			if (!err) begin
				case (phase)
					P_HDR_LO: begin
						case (w)
							HDR_DATA, HDR_CODE: begin
								kind = KIND_CODE;
								phase = P_ADR_HI;
							end
							HDR_SYM: begin
								kind = KIND_SYM;
								phase = P_ADR_HI;
							end
							HDR_FILE: begin
								kind = KIND_FILE;
								phase = P_CNT_HI;
							end
							HDR_LINE: begin
								kind = KIND_LINE;
								count = LINE_SKIP_BYTES;
								phase = P_SKIP;
							end
							default: begin
								err = 1'b1;
								phase = P_HDR_HI;
							end
						endcase
					end
					P_ADR_LO: begin
						addr = w;
						phase = P_CNT_HI;
					end
					P_CNT_LO: begin
						count = w;
						if (w == 16'd0)
							phase = P_HDR_HI;
						else if (kind == KIND_CODE)
							phase = P_WRD_HI;
						else
							phase = P_SKIP;
					end
					P_WRD_LO: begin
						r.write_valid = 1'b1;
						r.write_address = addr;
						r.write_data = w;
						addr = addr + 16'd1;
						count = count - 16'd1;
						phase = (count == 16'd0) ? P_HDR_HI : P_WRD_HI;
					end
					P_SKIP: begin
						count = count - 16'd1;
						if (count == 16'd0)
							phase = P_HDR_HI;
					end
					P_ADR_HI, P_CNT_HI, P_WRD_HI: begin
						hold = b;
						phase = phase_t'(phase + 1);
					end
					default: begin
						hold = b;
						phase = P_HDR_LO;
					end
				endcase
			end
			if (last) begin
				if (err)
					r.load_status = STAT_BAD;
				else if (phase != P_HDR_HI)
					r.load_status = STAT_TRUNC;
				else
					r.load_status = STAT_OK;
				clear();
			end
			writes_due.push_back(r);
		endfunction

		function void check_item(logic [39:0] tdata, logic tuser);
			result_t e;
			if (writes_due.size() == 0) begin
				$display("%0t: item with nothing due: tdata %h tuser %b", $time, tdata, tuser);
				errors++;
				return;
			end
			e = writes_due.pop_front();
			if (tuser !== e.write_valid) begin
				$display("%0t: write_valid expected %b actual %b", $time, e.write_valid, tuser);
				errors++;
			end
			if (tdata[15:0] !== e.write_address) begin
				$display("%0t: write_address expected %h actual %h", $time,
					e.write_address, tdata[15:0]);
				errors++;
			end
			if (tdata[31:16] !== e.write_data) begin
				$display("%0t: write_data expected %h actual %h", $time,
					e.write_data, tdata[31:16]);
				errors++;
			end
			if (tdata[33:32] !== e.load_status) begin
				$display("%0t: load_status expected %0d actual %0d", $time,
					e.load_status, tdata[33:32]);
				errors++;
			end
			if (tdata[39:34] !== 6'd0) begin
				$display("%0t: tdata padding expected 00 actual %h", $time, tdata[39:34]);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tuser;

	load_scoreboard sb = new();
	logic [7:0] file_bytes[$];
	int items_sent = 0;
	int ready_pct = 100;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	int idle_cycles = 0;

	object_file_section_loader u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				sb.check_item(m_tdata, m_tuser);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("%0t: timeout, %0d items still due", $time, sb.pending());
					$display("Some tests failed");
					$finish;
				end
			end
		end
	end

	// receiver: random ready, occasional stalls, one long hold on request
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if ($urandom_range(0, 299) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(15, 40)) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(1, 100) <= ready_pct);
			end
		end
	end

	function automatic void push_word(logic [15:0] w);
		file_bytes.push_back(w[15:8]);
		file_bytes.push_back(w[7:0]);
	endfunction

	task automatic send_byte(logic [7:0] b, logic last);
		int r;
		int gap;
		gap = 0;
		if (!no_idle) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				gap = 0;
			else if (r < 92)
				gap = $urandom_range(1, 3);
			else if (r < 98)
				gap = $urandom_range(4, 10);
			else
				gap = $urandom_range(20, 40);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		file_bytes.delete();
	endtask

	function automatic logic [15:0] pick_addr();
		if ($urandom_range(0, 3) == 0)
			return 16'hFFFF - 16'($urandom_range(0, 3));
		return 16'($urandom);
	endfunction

	function automatic int pick_count();
		if ($urandom_range(0, 9) == 0)
			return 0;
		return $urandom_range(1, 6);
	endfunction

	function automatic void build_file();
		int n;
		int sel;
		int cnt;
		int keep;
		logic [15:0] w;
		n = $urandom_range(1, 4);
		for (int s = 0; s < n; s++) begin
			sel = $urandom_range(0, 99);
			if (sel < 30) begin
				push_word(($urandom_range(0, 1) == 0) ? HDR_CODE : HDR_DATA);
				push_word(pick_addr());
				cnt = pick_count();
				push_word(16'(cnt));
				for (int k = 0; k < cnt; k++)
					push_word(16'($urandom));
			end else if (sel < 48) begin
				push_word(HDR_SYM);
				push_word(16'($urandom));
				cnt = pick_count();
				push_word(16'(cnt));
				for (int k = 0; k < cnt; k++)
					file_bytes.push_back(8'($urandom));
			end else if (sel < 63) begin
				push_word(HDR_FILE);
				cnt = pick_count();
				push_word(16'(cnt));
				for (int k = 0; k < cnt; k++)
					file_bytes.push_back(8'($urandom));
			end else if (sel < 78) begin
				push_word(HDR_LINE);
				for (int k = 0; k < 6; k++)
					file_bytes.push_back(8'($urandom));
			end else if (sel < 88) begin
				do w = 16'($urandom);
				while (w == HDR_CODE || w == HDR_DATA || w == HDR_SYM ||
					w == HDR_FILE || w == HDR_LINE);
				push_word(w);
				cnt = $urandom_range(0, 4);
				for (int k = 0; k < cnt; k++)
					file_bytes.push_back(8'($urandom));
			end else begin
				cnt = $urandom_range(1, 6);
				for (int k = 0; k < cnt; k++)
					file_bytes.push_back(8'($urandom));
			end
		end
		if ($urandom_range(0, 5) == 0) begin
			keep = $urandom_range(1, file_bytes.size());
			while (file_bytes.size() > keep)
				void'(file_bytes.pop_back());
		end
	endfunction

	initial begin
		bit hold_done;
		int r;
		hold_done = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// code section wrapping at the top of memory, last byte completes a write
		push_word(HDR_CODE);
		push_word(16'hFFFF);
		push_word(16'd2);
		push_word(16'h0000);
		push_word(16'hFFFF);
		send_file();
		// unknown header, rest ignored
		push_word(16'h0000);
		file_bytes.push_back(8'hFF);
		send_file();
		// line-number record
		push_word(HDR_LINE);
		file_bytes.push_back(8'h00);
		file_bytes.push_back(8'hFF);
		file_bytes.push_back(8'h55);
		file_bytes.push_back(8'hAA);
		file_bytes.push_back(8'h01);
		file_bytes.push_back(8'h80);
		send_file();
		// empty data section, then filename with one byte
		push_word(HDR_DATA);
		push_word(16'h8000);
		push_word(16'd0);
		push_word(HDR_FILE);
		push_word(16'd1);
		file_bytes.push_back(8'hA5);
		send_file();
		// lone header byte: truncated
		file_bytes.push_back(8'hFF);
		send_file();

		while (items_sent < 780) begin
			r = $urandom_range(0, 3);
			ready_pct = (r == 0) ? 100 : (r == 1) ? 80 : (r == 2) ? 50 : 20;
			no_idle = ($urandom_range(0, 3) == 0);
			if (!hold_done && items_sent >= 300) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
				no_idle = 1'b1;
			end
			build_file();
			send_file();
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
